// ===== design/rgb_to_yuv420_converter_defines.svh =====
// Assertion macros shared by the checker of the RGB to YUV 4:2:0 converter.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef RGB_TO_YUV420_CONVERTER_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_DEFINES_SVH

// Plain property checked at every clock edge outside reset.
`define R2Y_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication checked at every clock edge outside reset.
`define R2Y_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define R2Y_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/r2y420_pkg.sv =====
// Shared types and constants of the RGB to YUV 4:2:0 converter.
// Depends on nothing; used by every module of the block but the checker.
package r2y420_pkg;

  localparam int CFG_W = 13;
  localparam int PIX_W = 8;
  localparam int SUM_W = 16;

  typedef enum logic {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } r2y420_reg_t;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // BT.601 integer coefficients; chroma sums carry a bias of 128 * 256 plus rounding.
  localparam logic [SUM_W-1:0] Y_R      = 16'd66;
  localparam logic [SUM_W-1:0] Y_G      = 16'd129;
  localparam logic [SUM_W-1:0] Y_B      = 16'd25;
  localparam logic [SUM_W-1:0] U_R      = 16'd38;
  localparam logic [SUM_W-1:0] U_G      = 16'd74;
  localparam logic [SUM_W-1:0] U_B      = 16'd112;
  localparam logic [SUM_W-1:0] V_R      = 16'd112;
  localparam logic [SUM_W-1:0] V_G      = 16'd94;
  localparam logic [SUM_W-1:0] V_B      = 16'd18;
  localparam logic [SUM_W-1:0] ROUND    = 16'd128;
  localparam logic [SUM_W-1:0] C_BIAS   = 16'd32896;
  localparam logic [PIX_W-1:0] Y_OFFSET = 8'd16;

  typedef struct packed {
    logic chroma_valid;
    logic chroma_is_v;
    logic frame_end;
  } r2y420_pos_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } r2y420_rgb_t;

endpackage

// ===== design/r2y420_pos_counter.sv =====
// Column and row counter of the converter, with the chroma and frame-end flags.
// Depends on r2y420_pkg.
module r2y420_pos_counter
  import r2y420_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [CFG_W-1:0] line_width,
  input  logic [CFG_W-1:0] frame_height,
  output r2y420_pos_t      pos
);

  localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WWA = $clog2(MAX_WIDTH + 1);
  localparam int HWA = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = (WWA > CFG_W) ? WWA : CFG_W;
  localparam int HW  = (HWA > CFG_W) ? HWA : CFG_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] lw_ext, w_eff;
  logic [HW-1:0] fh_ext, h_eff;
  logic          last_col, last_row;

  always_comb begin
    lw_ext = WW'(line_width);
    if (lw_ext < WW'(2)) begin
      w_eff = WW'(2);
    end else if (lw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    fh_ext = HW'(frame_height);
    if (fh_ext < HW'(2)) begin
      h_eff = HW'(2);
    end else if (fh_ext > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext;
    end
  end

  assign last_col = (WW'(col_r) >= (w_eff - WW'(1)));
  assign last_row = (HW'(row_r) >= (h_eff - HW'(1)));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.chroma_valid = ~col_r[0];
  assign pos.chroma_is_v  = ~col_r[0] & row_r[0];
  assign pos.frame_end    = last_col & last_row;

endmodule

// ===== design/r2y420_csc.sv =====
// Colour space conversion of one pixel to luma and one chroma sample.
// Depends on r2y420_pkg.
module r2y420_csc
  import r2y420_pkg::*;
(
  input  r2y420_rgb_t      rgb,
  input  r2y420_pos_t      pos,
  output logic [PIX_W-1:0] luma,
  output logic [PIX_W-1:0] chroma
);

  logic [SUM_W-1:0] y_sum;
  logic [SUM_W-1:0] u_sum;
  logic [SUM_W-1:0] v_sum;

  // Chroma sums stay within 0..65535 thanks to the bias, so modular arithmetic is exact.
  assign y_sum = Y_R * SUM_W'(rgb.red) + Y_G * SUM_W'(rgb.green) + Y_B * SUM_W'(rgb.blue) + ROUND;
  assign u_sum = C_BIAS + U_B * SUM_W'(rgb.blue) - U_R * SUM_W'(rgb.red)
               - U_G * SUM_W'(rgb.green);
  assign v_sum = C_BIAS + V_R * SUM_W'(rgb.red) - V_G * SUM_W'(rgb.green)
               - V_B * SUM_W'(rgb.blue);

  assign luma = y_sum[SUM_W-1:PIX_W] + Y_OFFSET;

  always_comb begin
    if (!pos.chroma_valid) begin
      chroma = '0;
    end else if (pos.chroma_is_v) begin
      chroma = v_sum[SUM_W-1:PIX_W];
    end else begin
      chroma = u_sum[SUM_W-1:PIX_W];
    end
  end

endmodule

// ===== design/rgb_to_yuv420_converter.sv =====
// Top level of the RGB to YUV 4:2:0 converter: configuration, handshake and pipeline.
// Depends on r2y420_pkg, r2y420_pos_counter and r2y420_csc.
// The block takes one RGB pixel per clock and delivers one result per clock while the
// output side does not stall. A pixel transfer is registered together with its column
// and row flags, and the conversion runs between that register and the output register.
// Both stages advance whenever the next stage has room, and the output register holds
// a result while the downstream side stalls.
module rgb_to_yuv420_converter
  import r2y420_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // luma [7:0], chroma [15:8]
  output logic [1:0]       out_tuser,  // chroma_valid [0], chroma_is_v [1]
  output logic             out_tlast
);

  logic [CFG_W-1:0] line_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic             s1_valid_r;
  r2y420_rgb_t      s1_rgb_r;
  r2y420_pos_t      s1_pos_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_luma_r;
  logic [PIX_W-1:0] out_chroma_r;
  r2y420_pos_t      out_pos_r;
  r2y420_pos_t      cur_pos;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] chroma;
  logic             s2_ready;
  logic             s1_ready;
  logic             in_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (r2y420_reg_t'(cfg_addr))
        REG_LINE_WIDTH:   line_width_r   <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s2_ready  = ~out_valid_r | out_tready;
  assign s1_ready  = ~s1_valid_r | s2_ready;
  assign in_tready = s1_ready;
  assign in_xfer   = in_tvalid & s1_ready;

  r2y420_pos_counter #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_xfer),
    .line_width   (line_width_r),
    .frame_height (frame_height_r),
    .pos          (cur_pos)
  );

  r2y420_csc u_csc (
    .rgb    (s1_rgb_r),
    .pos    (s1_pos_r),
    .luma   (luma),
    .chroma (chroma)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_rgb_r <= r2y420_rgb_t'(in_tdata);
      s1_pos_r <= cur_pos;
    end
    if (s2_ready && s1_valid_r) begin
      out_luma_r   <= luma;
      out_chroma_r <= chroma;
      out_pos_r    <= s1_pos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_chroma_r, out_luma_r};
  assign out_tuser  = {out_pos_r.chroma_is_v, out_pos_r.chroma_valid};
  assign out_tlast  = out_pos_r.frame_end;

endmodule

// ===== design/r2y420_checker.sv =====
// Port-level checker of the RGB to YUV 4:2:0 converter, bound to the top level.
// Depends on rgb_to_yuv420_converter_defines.svh.
`include "rgb_to_yuv420_converter_defines.svh"

module r2y420_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `R2Y_ASSERT_IMPL(a_no_chroma_zero, out_tvalid && !out_tuser[0], out_tdata[15:8] == 8'd0 && !out_tuser[1], "chroma fields not zero without a chroma sample")
  `R2Y_ASSERT_IMPL(a_luma_range, out_tvalid, out_tdata[7:0] >= 8'd16 && out_tdata[7:0] <= 8'd235, "luma outside 16..235")
  `R2Y_ASSERT_IMPL(a_chroma_range, out_tvalid && out_tuser[0], out_tdata[15:8] >= 8'd16 && out_tdata[15:8] <= 8'd240, "chroma outside 16..240")
  `R2Y_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

endmodule

bind rgb_to_yuv420_converter r2y420_checker u_r2y420_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
